// ===== rtl/gufwc_pkg.sv =====
// ----------------------------------------------------------------------------
// gufwc_pkg: shared definitions of the grid union-find wall carver
// Label width, field codes, default sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package gufwc_pkg;

    localparam int MAX_SIDE_DEF  = 16;
    localparam int MAX_CELLS_DEF = 256;

    localparam int LABEL_W = 8;
    localparam int SIDE_W  = 5;
    localparam int COORD_W = 4;
    localparam int NB_W    = 5;
    localparam int IDX_W   = 10;
    localparam int PIX_W   = 6;

    localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 5'd6;

    typedef enum logic {
        REQ_JOIN    = 1'b0,
        REQ_RESTART = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        ST_REMOVED   = 2'd0,
        ST_CONNECTED = 2'd1,
        ST_OFF_GRID  = 2'd2,
        ST_RESTARTED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RDA,
        S_RDB,
        S_CMP,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

endpackage

// ===== rtl/gufwc_if.sv =====
// ----------------------------------------------------------------------------
// gufwc_if: channel interfaces of the grid union-find wall carver
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface gufwc_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [gufwc_pkg::COORD_W-1:0]      cell_row;
    logic [gufwc_pkg::COORD_W-1:0]      cell_col;
    logic [1:0]                         direction;

    modport source (output valid, output req_type, output cell_row, output cell_col,
                    output direction, input ready);
    modport sink   (input valid, input req_type, input cell_row, input cell_col,
                    input direction, output ready);
endinterface

interface gufwc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [gufwc_pkg::PIX_W-1:0]        wall_row;
    logic [gufwc_pkg::PIX_W-1:0]        wall_col;
    logic [gufwc_pkg::LABEL_W-1:0]      merged_label;

    modport source (output valid, output status, output wall_row, output wall_col,
                    output merged_label, input ready);
    modport sink   (input valid, input status, input wall_row, input wall_col,
                    input merged_label, output ready);
endinterface

interface gufwc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gufwc_pkg::SIDE_W-1:0]       data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grid_union_find_wall_carver.sv =====
// ----------------------------------------------------------------------------
// grid_union_find_wall_carver: disjoint-set engine for Kruskal maze carving
// Each grid cell holds a set label. A join request names a cell and a side;
// differing labels are merged and the removed wall's pixel position returned.
//
// Channels: i_req carries one request beat (join or restart), o_rsp returns
// exactly one response beat per request, i_cfg writes grid_side and is always
// ready. Write configuration only while no request is in flight.
// Steps: a join checks that both cells lie on the grid, reads both labels and
// compares them; a merge then runs the relabel scan, which compares one label a
// cycle through the single read port of the label memory. A restart and the
// sweep after reset write one label a cycle through its write port.
// Reset: grid_side returns to 6 and a sweep reloads every label with its own
// index; i_req is not ready until it ends.
// One request is in the block at a time: i_req is ready only when idle, and
// a stalled response holds in the output register until o_rsp.ready.
// ----------------------------------------------------------------------------
module grid_union_find_wall_carver #(
    parameter int MAX_SIDE  = gufwc_pkg::MAX_SIDE_DEF,
    parameter int MAX_CELLS = gufwc_pkg::MAX_CELLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gufwc_req_if.sink    i_req,
    gufwc_rsp_if.source  o_rsp,
    gufwc_cfg_if.sink    i_cfg
);
    import gufwc_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CELLS - 1);

    t_state              r_state, n_state;
    logic [SIDE_W-1:0]   r_grid_side;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic                r_restart_rsp, n_restart_rsp;
    logic                r_pv, n_pv;
    logic [ADDR_W-1:0]   r_pa, n_pa;
    logic [COORD_W-1:0]  r_row, n_row, r_col, n_col;
    logic [1:0]          r_dir, n_dir;
    logic [NB_W-1:0]     r_nr, n_nr, r_nc, n_nc;
    logic [ADDR_W-1:0]   r_cur, n_cur, r_nxt, n_nxt;
    logic [LABEL_W-1:0]  r_lab_cur, n_lab_cur, r_lab_nxt, n_lab_nxt;
    logic [1:0]          r_status, n_status;
    logic [PIX_W-1:0]    r_wall_row, n_wall_row, r_wall_col, n_wall_col;
    logic [LABEL_W-1:0]  r_label, n_label;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [LABEL_W-1:0]  ram_wdata, ram_rdata;

    logic [SIDE_W-1:0]   side;
    logic [NB_W-1:0]     nb_row, nb_col;
    logic                nb_off;
    logic [IDX_W-1:0]    idx_cur, idx_nxt;

    gufwc_label_ram #(
        .DEPTH (MAX_CELLS)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RST;
        end else if (i_cfg.valid) begin
            r_grid_side <= i_cfg.data;
        end
    end

    always_comb begin
        side    = (32'(r_grid_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : r_grid_side;
        nb_row  = NB_W'(r_row);
        nb_col  = NB_W'(r_col);
        nb_off  = (NB_W'(r_row) >= NB_W'(side)) || (NB_W'(r_col) >= NB_W'(side));
        case (t_dir'(r_dir))
            DIR_LEFT: begin
                if (r_col == '0) nb_off = 1'b1;
                nb_col = NB_W'(r_col) - NB_W'(1);
            end
            DIR_RIGHT: nb_col = NB_W'(r_col) + NB_W'(1);
            DIR_UP: begin
                if (r_row == '0) nb_off = 1'b1;
                nb_row = NB_W'(r_row) - NB_W'(1);
            end
            default: nb_row = NB_W'(r_row) + NB_W'(1);
        endcase
        if (nb_row >= NB_W'(side) || nb_col >= NB_W'(side)) nb_off = 1'b1;
        idx_cur = IDX_W'(r_row) * IDX_W'(side) + IDX_W'(r_col);
        idx_nxt = IDX_W'(nb_row) * IDX_W'(side) + IDX_W'(nb_col);
        if (32'(idx_cur) >= MAX_CELLS || 32'(idx_nxt) >= MAX_CELLS) nb_off = 1'b1;
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_restart_rsp = r_restart_rsp;
        n_pv          = 1'b0;
        n_pa          = r_pa;
        n_row         = r_row;
        n_col         = r_col;
        n_dir         = r_dir;
        n_nr          = r_nr;
        n_nc          = r_nc;
        n_cur         = r_cur;
        n_nxt         = r_nxt;
        n_lab_cur     = r_lab_cur;
        n_lab_nxt     = r_lab_nxt;
        n_status      = r_status;
        n_wall_row    = r_wall_row;
        n_wall_col    = r_wall_col;
        n_label       = r_label;
        ram_we        = r_pv && (ram_rdata == r_lab_nxt);
        ram_waddr     = r_pa;
        ram_wdata     = r_lab_cur;
        ram_raddr     = r_cnt;
        i_req.ready   = 1'b0;
        o_rsp.valid   = 1'b0;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = LABEL_W'(r_cnt);
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = r_restart_rsp ? S_OUT : S_IDLE;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_row      = i_req.cell_row;
                    n_col      = i_req.cell_col;
                    n_dir      = i_req.direction;
                    n_wall_row = '0;
                    n_wall_col = '0;
                    n_label    = '0;
                    if (t_req'(i_req.req_type) == REQ_RESTART) begin
                        n_status      = ST_RESTARTED;
                        n_restart_rsp = 1'b1;
                        n_cnt         = '0;
                        n_state       = S_INIT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_nr  = nb_row;
                n_nc  = nb_col;
                n_cur = ADDR_W'(idx_cur);
                n_nxt = ADDR_W'(idx_nxt);
                if (nb_off) begin
                    n_status = ST_OFF_GRID;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                ram_raddr = r_cur;
                n_state   = S_RDB;
            end
            S_RDB: begin
                ram_raddr = r_nxt;
                n_lab_cur = ram_rdata;
                n_state   = S_CMP;
            end
            S_CMP: begin
                n_lab_nxt = ram_rdata;
                n_label   = r_lab_cur;
                if (ram_rdata == r_lab_cur) begin
                    n_status = ST_CONNECTED;
                    n_state  = S_OUT;
                end else begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_raddr = r_cnt;
                n_pv      = 1'b1;
                n_pa      = r_cnt;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + ADDR_W'(1);
                end
            end
            S_DRAIN: begin
                n_status   = ST_REMOVED;
                n_wall_row = PIX_W'(r_row) + PIX_W'(r_nr) + PIX_W'(1);
                n_wall_col = PIX_W'(r_col) + PIX_W'(r_nc) + PIX_W'(1);
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) begin
                    n_restart_rsp = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cnt         <= '0;
            r_restart_rsp <= 1'b0;
            r_pv          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_restart_rsp <= n_restart_rsp;
            r_pv          <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa       <= n_pa;
        r_row      <= n_row;
        r_col      <= n_col;
        r_dir      <= n_dir;
        r_nr       <= n_nr;
        r_nc       <= n_nc;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_lab_cur  <= n_lab_cur;
        r_lab_nxt  <= n_lab_nxt;
        r_status   <= n_status;
        r_wall_row <= n_wall_row;
        r_wall_col <= n_wall_col;
        r_label    <= n_label;
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.wall_row     = r_wall_row;
    assign o_rsp.wall_col     = r_wall_col;
    assign o_rsp.merged_label = r_label;

endmodule

// ===== rtl/gufwc_label_ram.sv =====
// ----------------------------------------------------------------------------
// gufwc_label_ram: set label store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gufwc_label_ram #(
    parameter int DEPTH = gufwc_pkg::MAX_CELLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [gufwc_pkg::LABEL_W-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [gufwc_pkg::LABEL_W-1:0]    o_rdata
);
    import gufwc_pkg::*;

    logic [LABEL_W-1:0] r_mem [DEPTH];
    logic [LABEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_grid_union_find_wall_carver.sv =====
// ----------------------------------------------------------------------------
// tb_grid_union_find_wall_carver: self-checking bench for the wall carver
// Feeds join and restart requests through bursty valid/ready traffic against
// a stalling response sink, mirrors the cell label store and grid side in a
// local predictor, and compares every response beat field by field. The grid
// side is swept through zero, one, small, full and oversized values.
// ----------------------------------------------------------------------------
module tb_grid_union_find_wall_carver;

    timeunit 1ns;
    timeprecision 1ps;

    import gufwc_pkg::*;

    localparam int MAX_SIDE    = MAX_SIDE_DEF;
    localparam int NUM_CELLS   = MAX_CELLS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = MAX_CELLS_DEF + 40;
    localparam int PHASE_ITEMS = 58;

    typedef struct packed {
        t_req               kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_dir               dir;
    } join_req_t;

    typedef struct packed {
        t_status            status;
        logic [PIX_W-1:0]   wall_row;
        logic [PIX_W-1:0]   wall_col;
        logic [LABEL_W-1:0] label;
    } carve_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gufwc_req_if req_if ();
    gufwc_rsp_if rsp_if ();
    gufwc_cfg_if cfg_if ();

    grid_union_find_wall_carver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    join_req_t          requests_to_send[$];
    carve_rsp_t         outcomes_due[$];
    logic [LABEL_W-1:0] set_label[NUM_CELLS];
    logic [SIDE_W-1:0]  side_setting;

    int   mismatches     = 0;
    int   results_seen   = 0;
    int   cycles         = 0;
    int   gen_side       = 6;
    logic req_taken      = 1'b0;
    int   burst_left     = 8;
    int   gap_left       = 0;
    int   hold_left      = 0;
    bit   long_hold_done = 1'b0;
    int   pattern_cycle  = 0;
    int   stall_mode     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic join_req_t make_req(t_req k, int r, int c, t_dir d);
        join_req_t q;
        q.kind = k;
        q.row  = r[COORD_W-1:0];
        q.col  = c[COORD_W-1:0];
        q.dir  = d;
        return q;
    endfunction

    function automatic void reload_labels();
        foreach (set_label[i]) set_label[i] = LABEL_W'(i);
    endfunction

    function automatic carve_rsp_t carve_outcome(join_req_t rq);
        carve_rsp_t res;
        int side, r, c, nr, nc;
        logic [LABEL_W-1:0] keep, gone;
        res = '0;
        if (rq.kind == REQ_RESTART) begin
            reload_labels();
            res.status = ST_RESTARTED;
            return res;
        end
        side = side_setting;
        if (side > MAX_SIDE) side = MAX_SIDE;
        r = rq.row;
        c = rq.col;
        nr = r;
        nc = c;
        res.status = ST_OFF_GRID;
        if (r >= side || c >= side) return res;
        case (rq.dir)
            DIR_LEFT:  nc = c - 1;
            DIR_RIGHT: nc = c + 1;
            DIR_UP:    nr = r - 1;
            default:   nr = r + 1;
        endcase
        if (nr < 0 || nc < 0 || nr >= side || nc >= side) return res;
        keep = set_label[r * side + c];
        gone = set_label[nr * side + nc];
        res.label = keep;
        if (keep == gone) begin
            res.status = ST_CONNECTED;
            return res;
        end
        foreach (set_label[i]) begin
            if (set_label[i] == gone) set_label[i] = keep;
        end
        res.status   = ST_REMOVED;
        res.wall_row = PIX_W'(((2 * r + 1) + (2 * nr + 1)) / 2);
        res.wall_col = PIX_W'(((2 * c + 1) + (2 * nc + 1)) / 2);
        return res;
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    function automatic join_req_t random_request(int s);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return make_req(REQ_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                            t_dir'($urandom_range(0, 3)));
        if (pick < 16 || s == 0)
            return make_req(REQ_JOIN, $urandom_range(0, 15), $urandom_range(0, 15),
                            t_dir'($urandom_range(0, 3)));
        return make_req(REQ_JOIN, $urandom_range(0, s - 1), $urandom_range(0, s - 1),
                        t_dir'($urandom_range(0, 3)));
    endfunction

    always @(posedge i_clk) begin : monitor
        carve_rsp_t want;
        join_req_t  seen;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (!i_rst_n) begin
            reload_labels();
            side_setting = GRID_SIDE_RST;
        end else begin
            if (cfg_if.valid && cfg_if.ready) side_setting = cfg_if.data;
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: response beat with none expected, status %0d",
                             $time, rsp_if.status);
                end else begin
                    want = outcomes_due.pop_front();
                    check_field("status", want.status, rsp_if.status);
                    check_field("wall_row", want.wall_row, rsp_if.wall_row);
                    check_field("wall_col", want.wall_col, rsp_if.wall_col);
                    check_field("merged_label", want.label, rsp_if.merged_label);
                end
            end
            if (req_if.valid && req_if.ready) begin
                seen = make_req(t_req'(req_if.req_type), req_if.cell_row, req_if.cell_col,
                                t_dir'(req_if.direction));
                outcomes_due.push_back(carve_outcome(seen));
            end
        end
    end

    always @(negedge i_clk) begin : driver
        join_req_t outgoing;
        if (!req_if.valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (requests_to_send.size() > 0) begin
                outgoing = requests_to_send.pop_front();
                req_if.valid     <= 1'b1;
                req_if.req_type  <= outgoing.kind;
                req_if.cell_row  <= outgoing.row;
                req_if.cell_col  <= outgoing.col;
                req_if.direction <= outgoing.dir;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 150 && requests_to_send.size() > 4) begin
            // hold off long enough for the block to back up onto its input
            long_hold_done = 1'b1;
            hold_left      = 599;
            rsp_if.ready <= 1'b0;
        end else begin
            pattern_cycle++;
            if (pattern_cycle % 80 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_if.ready <= pattern_cycle[0];
            endcase
        end
    end

    task automatic wait_idle();
        while (requests_to_send.size() != 0 || req_if.valid || outcomes_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_grid_side(int v);
        wait_idle();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v[SIDE_W-1:0];
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        gen_side = (v > MAX_SIDE) ? MAX_SIDE : v;
    endtask

    initial begin : stimulus
        int side_plan[12];
        int sv;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_JOIN;
        req_if.cell_row  = '0;
        req_if.cell_col  = '0;
        req_if.direction = DIR_LEFT;
        rsp_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        side_plan = '{6, 16, 2, 31, 0, 1, -1, 17, 3, -1, 8, -1};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);

        // reset side of six: edges, cell off grid, merges and repeated joins
        requests_to_send.push_back(make_req(REQ_RESTART, 15, 15, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_LEFT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_UP));
        requests_to_send.push_back(make_req(REQ_JOIN, 5, 5, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 5, 5, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 15, 0, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 15, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 1, DIR_LEFT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 1, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 2, 2, DIR_UP));
        requests_to_send.push_back(make_req(REQ_JOIN, 1, 2, DIR_LEFT));
        requests_to_send.push_back(make_req(REQ_JOIN, 2, 2, DIR_UP));
        requests_to_send.push_back(make_req(REQ_JOIN, 5, 4, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 4, 5, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 5, 5, DIR_LEFT));

        set_grid_side(0);
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_RESTART, 0, 0, DIR_LEFT));

        set_grid_side(16);
        requests_to_send.push_back(make_req(REQ_JOIN, 15, 15, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 15, 14, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_UP));
        requests_to_send.push_back(make_req(REQ_JOIN, 15, 15, DIR_UP));

        set_grid_side(31);
        requests_to_send.push_back(make_req(REQ_JOIN, 15, 15, DIR_DOWN));
        requests_to_send.push_back(make_req(REQ_JOIN, 14, 15, DIR_DOWN));

        set_grid_side(1);
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_RIGHT));
        requests_to_send.push_back(make_req(REQ_JOIN, 0, 0, DIR_DOWN));

        // negative plan entries draw a random side
        foreach (side_plan[p]) begin
            sv = (side_plan[p] < 0) ? $urandom_range(3, 15) : side_plan[p];
            set_grid_side(sv);
            if ($urandom_range(0, 1) == 1)
                requests_to_send.push_back(make_req(REQ_RESTART, 0, 0, DIR_LEFT));
            repeat (PHASE_ITEMS) requests_to_send.push_back(random_request(gen_side));
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
